// ----- design/vrm_pkg.sv -----
// Shared types, register indexes and helpers for the voxel radius block.
`default_nettype none

package vrm_pkg;

    localparam int VALUE_W  = 8;
    localparam int POS_W    = 8;
    localparam int CENTRE_W = 16;
    localparam int SQ_W     = 32;
    localparam int DSQ_W    = 34;
    localparam int SUM_W    = 58;
    localparam int TALLY_W  = 25;
    localparam int RADIUS_W = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int QUEUE_DEPTH = 2;
    localparam int DIV_STEPS   = SUM_W;
    localparam int SQRT_STEPS  = RADIUS_W;

    localparam logic [VALUE_W-1:0] THRESHOLD_RESET = 8'd229;

    localparam logic [CFG_IDX_W-1:0] REG_CENTRE_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTRE_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTRE_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd4;

    typedef struct packed {
        logic [CENTRE_W-1:0] centre_x;
        logic [CENTRE_W-1:0] centre_y;
        logic [CENTRE_W-1:0] centre_z;
        logic                radius_mode;
        logic [VALUE_W-1:0]  threshold;
    } cfg_t;

    // Snapshot of one finished grid, handed from front to back.
    typedef struct packed {
        logic [SUM_W-1:0]   sum;
        logic [TALLY_W-1:0] tally;
        logic [DSQ_W-1:0]   maxsq;
        logic               radius_mode;
    } grid_sum_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // Absolute distance along one axis, position taken as Q8.8.
    function automatic logic [CENTRE_W-1:0] axis_diff(input logic [POS_W-1:0] pos,
                                                      input logic [CENTRE_W-1:0] centre);
        logic [CENTRE_W-1:0] p;
        p = {pos, 8'h00};
        return (p > centre) ? (p - centre) : (centre - p);
    endfunction

endpackage

`default_nettype wire

// ----- design/vrm_front.sv -----
// Front end: voxel intake, distance pipeline and per-grid accumulators.
`default_nettype none

module vrm_front (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [vrm_pkg::VALUE_W-1:0]       s_voxel_value,
    input  wire logic [vrm_pkg::POS_W-1:0]         s_pos_x,
    input  wire logic [vrm_pkg::POS_W-1:0]         s_pos_y,
    input  wire logic [vrm_pkg::POS_W-1:0]         s_pos_z,
    input  wire logic                              s_last_voxel,
    input  wire vrm_pkg::cfg_t                     cfg,
    input  wire vrm_pkg::queue_status_t            q_status,
    output logic                                   q_push,
    output vrm_pkg::grid_sum_t                     q_data
);

    logic advance;

    // stage A: axis differences
    logic                             a_valid_reg, a_qual_reg, a_last_reg;
    logic [vrm_pkg::CENTRE_W-1:0]     a_dx_reg, a_dy_reg, a_dz_reg;
    // stage B: squares
    logic                             b_valid_reg, b_qual_reg, b_last_reg;
    logic [vrm_pkg::SQ_W-1:0]         b_sx_reg, b_sy_reg, b_sz_reg;
    // stage C: squared distance
    logic                             c_valid_reg, c_qual_reg, c_last_reg;
    logic [vrm_pkg::DSQ_W-1:0]        c_dsq_reg;

    logic [vrm_pkg::SUM_W-1:0]        sum_reg, sum_next;
    logic [vrm_pkg::TALLY_W-1:0]      tally_reg, tally_next;
    logic [vrm_pkg::DSQ_W-1:0]        maxsq_reg, maxsq_next;
    logic [vrm_pkg::SUM_W:0]          sum_wide;

    // stall the whole pipe only while a finished grid waits for queue room
    assign advance = !(c_valid_reg && c_last_reg && q_status.full);
    assign s_ready = advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else if (advance) begin
            a_valid_reg <= s_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            a_qual_reg <= s_voxel_value > cfg.threshold;
            a_last_reg <= s_last_voxel;
            a_dx_reg   <= vrm_pkg::axis_diff(s_pos_x, cfg.centre_x);
            a_dy_reg   <= vrm_pkg::axis_diff(s_pos_y, cfg.centre_y);
            a_dz_reg   <= vrm_pkg::axis_diff(s_pos_z, cfg.centre_z);
            b_qual_reg <= a_qual_reg;
            b_last_reg <= a_last_reg;
            b_sx_reg   <= vrm_pkg::SQ_W'(a_dx_reg) * vrm_pkg::SQ_W'(a_dx_reg);
            b_sy_reg   <= vrm_pkg::SQ_W'(a_dy_reg) * vrm_pkg::SQ_W'(a_dy_reg);
            b_sz_reg   <= vrm_pkg::SQ_W'(a_dz_reg) * vrm_pkg::SQ_W'(a_dz_reg);
            c_qual_reg <= b_qual_reg;
            c_last_reg <= b_last_reg;
            c_dsq_reg  <= {2'b00, b_sx_reg} + {2'b00, b_sy_reg} + {2'b00, b_sz_reg};
        end
    end

    always_comb begin
        sum_next   = sum_reg;
        tally_next = tally_reg;
        maxsq_next = maxsq_reg;
        sum_wide   = {1'b0, sum_reg} + {{(vrm_pkg::SUM_W - vrm_pkg::DSQ_W + 1){1'b0}}, c_dsq_reg};
        if (c_valid_reg && c_qual_reg) begin
            // saturate sum and tally on overlong streams
            sum_next = sum_wide[vrm_pkg::SUM_W] ? {vrm_pkg::SUM_W{1'b1}}
                                                : sum_wide[vrm_pkg::SUM_W-1:0];
            if (tally_reg != {vrm_pkg::TALLY_W{1'b1}}) begin
                tally_next = tally_reg + 1'b1;
            end
            if (c_dsq_reg > maxsq_reg) begin
                maxsq_next = c_dsq_reg;
            end
        end
    end

    assign q_push            = c_valid_reg && c_last_reg && advance;
    assign q_data.sum        = sum_next;
    assign q_data.tally      = tally_next;
    assign q_data.maxsq      = maxsq_next;
    assign q_data.radius_mode = cfg.radius_mode;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg   <= '0;
            tally_reg <= '0;
            maxsq_reg <= '0;
        end else if (advance && c_valid_reg) begin
            if (c_last_reg) begin
                sum_reg   <= '0;
                tally_reg <= '0;
                maxsq_reg <= '0;
            end else begin
                sum_reg   <= sum_next;
                tally_reg <= tally_next;
                maxsq_reg <= maxsq_next;
            end
        end
    end

`ifndef ASSERT_OFF
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (c_valid_reg && c_last_reg))
        else $error("front stalled without a pending grid");
`endif

endmodule

`default_nettype wire

// ----- design/vrm_fifo.sv -----
// Short queue of finished grid snapshots between front and back.
`default_nettype none

module vrm_fifo (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   push,
    input  wire vrm_pkg::grid_sum_t     push_data,
    input  wire logic                   pop,
    output vrm_pkg::grid_sum_t          head_data,
    output vrm_pkg::queue_status_t      status
);

    localparam int PTR_W = $clog2(vrm_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(vrm_pkg::QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(vrm_pkg::QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(vrm_pkg::QUEUE_DEPTH - 1);

    vrm_pkg::grid_sum_t  entry_reg [vrm_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]    count_reg;

    assign status.full  = (count_reg == DEPTH_C);
    assign status.empty = (count_reg == '0);
    assign head_data    = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

`ifndef ASSERT_OFF
    assert property (@(posedge aclk) disable iff (!aresetn) push |-> !status.full)
        else $error("push into full queue");
`endif
`ifndef ASSERT_OFF
    assert property (@(posedge aclk) disable iff (!aresetn) pop |-> !status.empty)
        else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

// ----- design/vrm_back.sv -----
// Back end: mean by restoring division, integer square root, result register.
`default_nettype none

module vrm_back (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire vrm_pkg::queue_status_t            q_status,
    input  wire vrm_pkg::grid_sum_t                q_head,
    output logic                                   q_pop,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [vrm_pkg::RADIUS_W-1:0]           m_radius,
    output logic [vrm_pkg::TALLY_W-1:0]            m_occupied_count,
    output logic                                   m_grid_empty
);

    localparam int CNT_W  = $clog2(vrm_pkg::DIV_STEPS);
    localparam int SREM_W = vrm_pkg::RADIUS_W + 2;
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(vrm_pkg::DIV_STEPS - 1);
    localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(vrm_pkg::SQRT_STEPS - 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_SQRT = 4'b0100,
        ST_OUT  = 4'b1000
    } back_state_t;

    back_state_t                     state_reg, state_next;
    logic [CNT_W-1:0]                cnt_reg, cnt_next;
    logic [vrm_pkg::TALLY_W-1:0]     tally_reg, tally_next;
    logic                            empty_reg, empty_next;
    logic [vrm_pkg::TALLY_W-1:0]     drem_reg, drem_next;
    logic [vrm_pkg::SUM_W-1:0]       quo_reg, quo_next;
    logic [vrm_pkg::DSQ_W-1:0]       sqop_reg, sqop_next;
    logic [SREM_W-1:0]               srem_reg, srem_next;
    logic [vrm_pkg::RADIUS_W-1:0]    root_reg, root_next;
    logic                            m_valid_reg, m_valid_next;
    logic [vrm_pkg::RADIUS_W-1:0]    m_radius_reg, m_radius_next;
    logic [vrm_pkg::TALLY_W-1:0]     m_count_reg, m_count_next;
    logic                            m_empty_reg, m_empty_next;

    logic [vrm_pkg::TALLY_W:0]       d_shift;
    logic [vrm_pkg::SUM_W-1:0]       d_quo;
    logic [SREM_W+1:0]               s_shift, s_trial;

    always_comb begin
        d_shift = {drem_reg, quo_reg[vrm_pkg::SUM_W-1]};
        s_shift = {srem_reg, sqop_reg[vrm_pkg::DSQ_W-1 -: 2]};
        s_trial = {2'b00, root_reg, 2'b01};
        d_quo   = '0;

        state_next    = state_reg;
        cnt_next      = cnt_reg;
        tally_next    = tally_reg;
        empty_next    = empty_reg;
        drem_next     = drem_reg;
        quo_next      = quo_reg;
        sqop_next     = sqop_reg;
        srem_next     = srem_reg;
        root_next     = root_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_radius_next = m_radius_reg;
        m_count_next  = m_count_reg;
        m_empty_next  = m_empty_reg;
        q_pop         = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (!q_status.empty) begin
                    q_pop      = 1'b1;
                    tally_next = q_head.tally;
                    root_next  = '0;
                    srem_next  = '0;
                    drem_next  = '0;
                    sqop_next  = q_head.maxsq;
                    quo_next   = q_head.sum;
                    empty_next = (q_head.tally == '0);
                    if (q_head.tally == '0) begin
                        state_next = ST_OUT;
                    end else if (q_head.radius_mode) begin
                        cnt_next   = SQRT_LAST;
                        state_next = ST_SQRT;
                    end else begin
                        cnt_next   = DIV_LAST;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                // one quotient bit per cycle
                if (d_shift >= {1'b0, tally_reg}) begin
                    drem_next = vrm_pkg::TALLY_W'(d_shift - {1'b0, tally_reg});
                    d_quo     = {quo_reg[vrm_pkg::SUM_W-2:0], 1'b1};
                end else begin
                    drem_next = d_shift[vrm_pkg::TALLY_W-1:0];
                    d_quo     = {quo_reg[vrm_pkg::SUM_W-2:0], 1'b0};
                end
                quo_next = d_quo;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    // mean of squares never exceeds the largest square
                    sqop_next  = d_quo[vrm_pkg::DSQ_W-1:0];
                    cnt_next   = SQRT_LAST;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                // one root bit per cycle, two operand bits consumed
                sqop_next = {sqop_reg[vrm_pkg::DSQ_W-3:0], 2'b00};
                if (s_shift >= s_trial) begin
                    srem_next = SREM_W'(s_shift - s_trial);
                    root_next = {root_reg[vrm_pkg::RADIUS_W-2:0], 1'b1};
                end else begin
                    srem_next = s_shift[SREM_W-1:0];
                    root_next = {root_reg[vrm_pkg::RADIUS_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_radius_next = empty_reg ? '0 : root_reg;
                    m_count_next  = tally_reg;
                    m_empty_next  = empty_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg      <= cnt_next;
        tally_reg    <= tally_next;
        empty_reg    <= empty_next;
        drem_reg     <= drem_next;
        quo_reg      <= quo_next;
        sqop_reg     <= sqop_next;
        srem_reg     <= srem_next;
        root_reg     <= root_next;
        m_radius_reg <= m_radius_next;
        m_count_reg  <= m_count_next;
        m_empty_reg  <= m_empty_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_radius         = m_radius_reg;
    assign m_occupied_count = m_count_reg;
    assign m_grid_empty     = m_empty_reg;

`ifndef ASSERT_OFF
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_grid_empty) |-> (m_radius == '0 && m_occupied_count == '0))
        else $error("empty grid reported with nonzero radius or count");
`endif
`ifndef ASSERT_OFF
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> (state_reg != ST_IDLE))
        else $error("popped grid not taken up by the sequencer");
`endif

endmodule

`default_nettype wire

// ----- design/voxel_rms_or_max_radius.sv -----
// Top level: configuration registers and voxel radius front/queue/back.
//
//  channel  | dir | handshake           | payload
//  ---------+-----+---------------------+---------------------------------------------
//  s_       | in  | s_valid / s_ready   | voxel_value, pos_x, pos_y, pos_z, last_voxel
//  m_       | out | m_valid / m_ready   | radius, occupied_count, grid_empty
//  cfg_     | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// Voxels enter one per cycle, while s_ready is high, through a three-stage distance pipeline.
// With an idle back end, rms mode runs the restoring divider and then the integer root after
// the last voxel; maximum mode runs the root alone, and an empty grid goes straight to output.
// The queue holds two finished grids; s_ready drops only while a third waits.
// Reset is synchronous and clears accumulators, queue and sequencer state.
`default_nettype none

module voxel_rms_or_max_radius (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [vrm_pkg::VALUE_W-1:0]        s_voxel_value,
    input  wire logic [vrm_pkg::POS_W-1:0]          s_pos_x,
    input  wire logic [vrm_pkg::POS_W-1:0]          s_pos_y,
    input  wire logic [vrm_pkg::POS_W-1:0]          s_pos_z,
    input  wire logic                               s_last_voxel,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [vrm_pkg::RADIUS_W-1:0]            m_radius,
    output logic [vrm_pkg::TALLY_W-1:0]             m_occupied_count,
    output logic                                    m_grid_empty,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [vrm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [vrm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    vrm_pkg::cfg_t           cfg_reg;
    vrm_pkg::queue_status_t  q_status;
    vrm_pkg::grid_sum_t      q_push_data, q_head;
    logic                    q_push, q_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.centre_x    <= '0;
            cfg_reg.centre_y    <= '0;
            cfg_reg.centre_z    <= '0;
            cfg_reg.radius_mode <= 1'b0;
            cfg_reg.threshold   <= vrm_pkg::THRESHOLD_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                vrm_pkg::REG_CENTRE_X:  cfg_reg.centre_x    <= cfg_data;
                vrm_pkg::REG_CENTRE_Y:  cfg_reg.centre_y    <= cfg_data;
                vrm_pkg::REG_CENTRE_Z:  cfg_reg.centre_z    <= cfg_data;
                vrm_pkg::REG_MODE:      cfg_reg.radius_mode <= cfg_data[0];
                vrm_pkg::REG_THRESHOLD: cfg_reg.threshold   <= cfg_data[vrm_pkg::VALUE_W-1:0];
                default: begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    vrm_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_voxel_value (s_voxel_value),
        .s_pos_x       (s_pos_x),
        .s_pos_y       (s_pos_y),
        .s_pos_z       (s_pos_z),
        .s_last_voxel  (s_last_voxel),
        .cfg           (cfg_reg),
        .q_status      (q_status),
        .q_push        (q_push),
        .q_data        (q_push_data)
    );

    vrm_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .head_data (q_head),
        .status    (q_status)
    );

    vrm_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_status         (q_status),
        .q_head           (q_head),
        .q_pop            (q_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_radius         (m_radius),
        .m_occupied_count (m_occupied_count),
        .m_grid_empty     (m_grid_empty)
    );

endmodule

`default_nettype wire
